### hdl/dfrb_pkg.sv
// ----------------------------------------------------------------------------
// dfrb_pkg
// Shared types and constants for the delimited frame receive ring buffer.
// ----------------------------------------------------------------------------
package dfrb_pkg;

  localparam int LEN_W     = 6;
  localparam int CFG_IDX_W = 1;

  // Register reset values: '$' opens a frame, ':' closes it
  localparam logic [7:0] START_CHAR_RST = 8'd36;
  localparam logic [7:0] END_CHAR_RST   = 8'd58;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_CHAR = 1'b0,
    REG_END_CHAR   = 1'b1
  } cfg_reg_t;

  // Request kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // Request word
  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } req_word_t;

  // Response word
  typedef struct packed {
    logic [7:0]       payload_byte;
    logic             byte_valid;
    logic             last;
    logic [LEN_W-1:0] length;
    logic             frame_done;
    logic             dropped;
  } rsp_word_t;

  // Framer decision for one received byte
  typedef struct packed {
    logic write;       // byte goes into the ring
    logic frame_done;  // stored byte closes the frame
    logic drop;        // framer wanted it, ring is full
  } byte_dec_t;

endpackage

### hdl/dfrb_ram.sv
// ----------------------------------------------------------------------------
// dfrb_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module dfrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/dfrb_framer.sv
// ----------------------------------------------------------------------------
// dfrb_framer
// Two-state receive framer: decides whether a received byte is stored.
// ----------------------------------------------------------------------------
module dfrb_framer import dfrb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_en,     // byte word accepted this cycle
  input  logic [7:0] rx_byte,
  input  logic [7:0] start_char,
  input  logic [7:0] end_char,
  input  logic       full,
  output byte_dec_t  dec
);

  logic in_frame;
  logic store;
  logic closes;

  // Waiting: only the start char is kept. In frame: everything is kept.
  always_comb begin
    store          = in_frame || (rx_byte == start_char);
    closes         = in_frame && (rx_byte == end_char);
    dec.write      = store && !full;
    dec.frame_done = closes && !full;
    dec.drop       = store && full;
  end

  // Framer state only moves when the byte really lands in the ring
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
    end else if (byte_en && dec.write) begin
      in_frame <= !closes;
    end
  end

endmodule

### hdl/dfrb_seq.sv
// ----------------------------------------------------------------------------
// dfrb_seq
// Ring pointers, pop walker and response register around the byte RAM.
// ----------------------------------------------------------------------------
module dfrb_seq import dfrb_pkg::*; #(
  parameter int BUF_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  req_word_t  req,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output rsp_word_t  rsp,
  input  logic [7:0] start_char,
  input  logic [7:0] end_char,
  input  byte_dec_t  dec,
  output logic       full,
  output logic       byte_en
);

  localparam int AW = $clog2(BUF_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(BUF_DEPTH - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SKIP = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  function automatic logic [AW-1:0] nxt(input logic [AW-1:0] idx);
    return (idx == LAST_IDX) ? '0 : idx + 1'b1;
  endfunction

  state_t    state, state_next;
  logic [AW-1:0] wr_idx, wr_idx_next;
  logic [AW-1:0] rd_idx, rd_idx_next;
  logic [AW-1:0] sp, sp_next;        // walk pointer, RAM data belongs to it
  logic [AW-1:0] pay, pay_next;      // first payload entry
  logic [AW-1:0] fin, fin_next;      // entry after the end char
  logic [AW-1:0] n, n_next;          // payload length
  logic [AW-1:0] k, k_next;          // bytes sent so far
  logic          out_free;
  logic          accept;
  logic          out_load;
  rsp_word_t     out_next;
  logic          we;
  logic [7:0]    rd_data;
  logic          emit_last;

  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == ST_IDLE) && out_free;
  assign accept    = req_valid && req_ready;
  assign byte_en   = accept && (req.kind == KIND_BYTE);
  assign full      = (nxt(wr_idx) == rd_idx);
  assign emit_last = (k == n - 1'b1);

  // Byte store; the read address is the next walk pointer, so the registered read data belongs to the walk pointer
  dfrb_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (wr_idx),
    .wdata (req.rx_byte),
    .raddr (sp_next),
    .rdata (rd_data)
  );

  // Walk control
  always_comb begin
    state_next  = state;
    wr_idx_next = wr_idx;
    rd_idx_next = rd_idx;
    sp_next     = sp;
    pay_next    = pay;
    fin_next    = fin;
    n_next      = n;
    k_next      = k;
    out_load    = 1'b0;
    out_next    = '0;
    we          = 1'b0;
    unique case (state)
      ST_IDLE: begin
        sp_next = rd_idx;
        if (accept) begin
          if (req.kind == KIND_BYTE) begin
            out_load            = 1'b1;
            out_next.last       = 1'b1;
            out_next.frame_done = dec.frame_done;
            out_next.dropped    = dec.drop;
            if (dec.write) begin
              we          = 1'b1;
              wr_idx_next = nxt(wr_idx);
            end
          end else begin
            state_next = ST_SKIP;
          end
        end
      end
      // Hunt for the start char
      ST_SKIP: begin
        if (sp == wr_idx) begin
          if (out_free) begin
            out_load      = 1'b1;
            out_next.last = 1'b1;
            rd_idx_next   = sp;
            state_next    = ST_IDLE;
          end
        end else if (rd_data == start_char) begin
          sp_next    = nxt(sp);
          pay_next   = nxt(sp);
          n_next     = '0;
          state_next = ST_SCAN;
        end else begin
          sp_next = nxt(sp);
        end
      end
      // Count payload up to the end char
      ST_SCAN: begin
        if (sp == wr_idx) begin
          if (out_free) begin
            out_load      = 1'b1;
            out_next.last = 1'b1;
            rd_idx_next   = sp;
            state_next    = ST_IDLE;
          end
        end else if (rd_data == end_char) begin
          if (n == '0) begin
            if (out_free) begin
              out_load      = 1'b1;
              out_next.last = 1'b1;
              rd_idx_next   = nxt(sp);
              state_next    = ST_IDLE;
            end
          end else begin
            fin_next   = nxt(sp);
            sp_next    = pay;
            k_next     = '0;
            state_next = ST_EMIT;
          end
        end else begin
          n_next  = n + 1'b1;
          sp_next = nxt(sp);
        end
      end
      // Re-read the closed frame and send its payload
      ST_EMIT: begin
        if (out_free) begin
          out_load              = 1'b1;
          out_next.payload_byte = rd_data;
          out_next.byte_valid   = 1'b1;
          out_next.last         = emit_last;
          out_next.length       = emit_last ? LEN_W'(n) : '0;
          sp_next               = nxt(sp);
          k_next                = k + 1'b1;
          if (emit_last) begin
            rd_idx_next = fin;
            state_next  = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wr_idx    <= '0;
      rd_idx    <= '0;
      sp        <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state  <= state_next;
      wr_idx <= wr_idx_next;
      rd_idx <= rd_idx_next;
      sp     <= sp_next;
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Walk bookkeeping and response payload
  always_ff @(posedge clk) begin
    pay <= pay_next;
    fin <= fin_next;
    n   <= n_next;
    k   <= k_next;
    if (out_load) begin
      rsp <= out_next;
    end
  end

  // A write never lands on a full ring
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    we |-> !full)
    else $error("ring written while full");

  // Payload send stays inside the counted frame
  a_emit_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (n != '0) && (k < n))
    else $error("payload index out of range");

  // A final payload byte always carries a nonzero length
  a_last_len: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.byte_valid && rsp.last) |-> (rsp.length != '0))
    else $error("final payload byte without length");

  // The write pointer does not move while a pop skips or scans
  a_ptr_hold: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SKIP || state == ST_SCAN) && $past(state != ST_IDLE))
      |-> $stable(wr_idx))
    else $error("write pointer moved during pop");

  // Requests are refused while a pop walks the ring
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !req_ready)
    else $error("request taken during pop");

endmodule

### hdl/delimited_frame_ring_buffer_top.sv
// ----------------------------------------------------------------------------
// delimited_frame_ring_buffer_top
// Receive ring buffer that keeps delimited frames and pops their payloads.
//
//   channel | signals                        | direction | word
//   --------+--------------------------------+-----------+------------------
//   req     | req_valid, req_ready, req      | in        | kind, rx_byte
//   rsp     | rsp_valid, rsp_ready, rsp      | out       | payload bytes
//   cfg     | cfg_valid, cfg_ready,          | in        | start/end chars
//           | cfg_index, cfg_data            |           |
//
// A byte word is handled while idle; its single response word is registered.
// A pop skips the entries before the start char, counts the payload up to the
// end char and then re-reads the payload: the one RAM read port walks one
// entry per cycle while rsp is not stalled.
// One word is processed at a time; a stalled rsp holds the walk in place.
// Reset is synchronous; the byte RAM needs no clearing pass.
// ----------------------------------------------------------------------------
module delimited_frame_ring_buffer_top import dfrb_pkg::*; #(
  parameter int BUF_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  req_word_t            req,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output rsp_word_t            rsp,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  logic [7:0] start_char;
  logic [7:0] end_char;
  byte_dec_t  dec;
  logic       full;
  logic       byte_en;

  assign cfg_ready = 1'b1;

  // Delimiter registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_char <= START_CHAR_RST;
      end_char   <= END_CHAR_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_START_CHAR: start_char <= cfg_data;
        REG_END_CHAR:   end_char   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  dfrb_framer u_framer (
    .clk        (clk),
    .rst        (rst),
    .byte_en    (byte_en),
    .rx_byte    (req.rx_byte),
    .start_char (start_char),
    .end_char   (end_char),
    .full       (full),
    .dec        (dec)
  );

  dfrb_seq #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .start_char (start_char),
    .end_char   (end_char),
    .dec        (dec),
    .full       (full),
    .byte_en    (byte_en)
  );

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the delimited frame receive ring buffer.
//
// Byte and pop words are queued by a stimulus thread, sent by a bursty
// driver and predicted at acceptance by a behavioral ring model. A monitor
// with its own stall pattern checks every response word in order. The
// start/end characters are reprogrammed between phases while the block idles.
// ----------------------------------------------------------------------------
module tb;
  import dfrb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH    = 64;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 32;
  localparam int SHOW_MAX      = 10;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_ready;
  req_word_t            req       = '0;
  logic                 rsp_valid;
  logic                 rsp_ready = 1'b0;
  rsp_word_t            rsp;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_START_CHAR;
  logic [7:0]           cfg_data  = '0;

  delimited_frame_ring_buffer_top #(.BUF_DEPTH(RING_DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Words waiting for the driver, response words due from the block
  req_word_t req_words [$];
  rsp_word_t due_words [$];

  // Ring model state
  logic [7:0]  ring [RING_DEPTH];
  int unsigned wr_idx   = 0;
  int unsigned rd_idx   = 0;
  logic        in_frame = 1'b0;
  logic [7:0]  start_ch = START_CHAR_RST;
  logic [7:0]  end_ch   = END_CHAR_RST;

  // Run statistics and error count
  int n_bytes, n_pops, n_closed, n_drops, n_payload, n_empty, n_settings;
  int n_errors;

  function automatic int unsigned ring_next(int unsigned i);
    return (i == RING_DEPTH - 1) ? 0 : i + 1;
  endfunction

  // Apply one accepted word to the ring model and queue its responses
  function automatic void frame_predict(req_word_t w);
    rsp_word_t  r;
    logic [7:0] body [$];
    logic       keep;
    logic       closes;
    r = '0;
    r.last = 1'b1;
    if (w.kind == KIND_BYTE) begin
      n_bytes++;
      keep   = in_frame || (w.rx_byte == start_ch);
      closes = in_frame && (w.rx_byte == end_ch);
      if (keep) begin
        if (ring_next(wr_idx) == rd_idx) begin
          r.dropped = 1'b1;
          n_drops++;
        end else begin
          ring[wr_idx] = w.rx_byte;
          wr_idx       = ring_next(wr_idx);
          in_frame     = !closes;
          r.frame_done = closes;
          if (closes) n_closed++;
        end
      end
      due_words.push_back(r);
    end else begin
      n_pops++;
      // skip to a start char
      while (rd_idx != wr_idx && ring[rd_idx] != start_ch) rd_idx = ring_next(rd_idx);
      if (rd_idx != wr_idx) begin
        rd_idx = ring_next(rd_idx);
        while (rd_idx != wr_idx && ring[rd_idx] != end_ch) begin
          body.push_back(ring[rd_idx]);
          rd_idx = ring_next(rd_idx);
        end
        // open frame: everything scanned is consumed, no payload
        if (rd_idx == wr_idx) body.delete();
        else rd_idx = ring_next(rd_idx);
      end
      if (body.size() == 0) begin
        n_empty++;
        due_words.push_back(r);
      end else begin
        foreach (body[k]) begin
          r              = '0;
          r.payload_byte = body[k];
          r.byte_valid   = 1'b1;
          r.last         = (k == body.size() - 1);
          r.length       = r.last ? LEN_W'(body.size()) : '0;
          due_words.push_back(r);
          n_payload++;
        end
      end
    end
  endfunction

  // Driver: bursts of words with random gaps
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) frame_predict(req);
      if (!req_valid || req_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_valid <= 1'b0;
        end else if (req_words.size() != 0) begin
          req_valid <= 1'b1;
          req       <= req_words.pop_front();
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each response word, stall on a rotating pattern
  logic [15:0] stall_pat = 16'hFFFF;
  logic [7:0]  pat_age   = '0;

  always @(posedge clk) begin
    rsp_word_t want;
    logic      bad;
    if (!rst && rsp_valid && rsp_ready) begin
      if (due_words.size() == 0) begin
        n_errors++;
        if (n_errors <= SHOW_MAX)
          $display("%0t: unexpected response word %p", $realtime, rsp);
      end else begin
        want = due_words.pop_front();
        bad  = (rsp.payload_byte !== want.payload_byte) ||
               (rsp.byte_valid   !== want.byte_valid)   ||
               (rsp.last         !== want.last)         ||
               (rsp.length       !== want.length)       ||
               (rsp.frame_done   !== want.frame_done)   ||
               (rsp.dropped      !== want.dropped);
        if (bad) begin
          n_errors++;
          if (n_errors <= SHOW_MAX)
            $display("%0t: response word differs: expected %p, actual %p",
                     $realtime, want, rsp);
        end
      end
    end
    pat_age = pat_age + 1'b1;
    if (pat_age == 0) begin
      if ($urandom_range(0, 2) == 0) stall_pat = 16'hFFFF;
      else stall_pat = 16'($urandom()) | 16'h0001;
    end
    rsp_ready <= stall_pat[0];
    stall_pat = {stall_pat[0], stall_pat[15:1]};
  end

  function automatic void queue_word(logic kind, logic [7:0] b);
    req_word_t w;
    w.kind    = kind;
    w.rx_byte = b;
    req_words.push_back(w);
  endfunction

  // Mostly uniform, sometimes the extremes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Wait until every word is sent and answered, then let the block settle
  task automatic wait_idle();
    do @(posedge clk);
    while (req_words.size() != 0 || req_valid || due_words.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Program both delimiter chars, back to back on the cfg channel
  task automatic write_chars(logic [7:0] s, logic [7:0] e);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= REG_START_CHAR;
    cfg_data  <= s;
    do @(posedge clk); while (!cfg_ready);
    start_ch = s;
    cfg_index <= REG_END_CHAR;
    cfg_data  <= e;
    do @(posedge clk); while (!cfg_ready);
    end_ch = e;
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // Random traffic: mostly well-formed frames, some open frames and noise
  task automatic random_traffic(int target, int pop_pct);
    int counted;
    int r;
    int len;
    counted = 0;
    while (counted < target) begin
      r = $urandom_range(0, 99);
      if (r < pop_pct) begin
        queue_word(KIND_POP, pick_byte());
        counted++;
      end else if (r < pop_pct + 30) begin
        len = ($urandom_range(0, 11) == 0) ? $urandom_range(7, 61) : $urandom_range(0, 6);
        queue_word(KIND_BYTE, start_ch);
        for (int k = 0; k < len; k++) queue_word(KIND_BYTE, pick_byte());
        queue_word(KIND_BYTE, end_ch);
        counted += len + 2;
      end else if (r < pop_pct + 38) begin
        len = $urandom_range(0, 5);
        queue_word(KIND_BYTE, start_ch);
        for (int k = 0; k < len; k++) queue_word(KIND_BYTE, pick_byte());
        counted += len + 1;
      end else begin
        queue_word(KIND_BYTE, pick_byte());
        counted++;
      end
    end
  endtask

  // Stimulus and end of run
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    n_settings = 1;

    // pop with nothing stored: no start found
    queue_word(KIND_POP, 8'h00);
    // non-start bytes while waiting are ignored
    queue_word(KIND_BYTE, 8'h00);
    queue_word(KIND_BYTE, 8'hFF);
    // closed frame carrying both extremes
    queue_word(KIND_BYTE, START_CHAR_RST);
    queue_word(KIND_BYTE, 8'h00);
    queue_word(KIND_BYTE, 8'hFF);
    queue_word(KIND_BYTE, END_CHAR_RST);
    queue_word(KIND_POP, 8'hFF);
    // empty payload
    queue_word(KIND_BYTE, START_CHAR_RST);
    queue_word(KIND_BYTE, END_CHAR_RST);
    queue_word(KIND_POP, 8'h5A);
    // frame still open when popped, then closed without its start
    queue_word(KIND_BYTE, START_CHAR_RST);
    queue_word(KIND_BYTE, 8'h41);
    queue_word(KIND_POP, 8'hA5);
    queue_word(KIND_BYTE, END_CHAR_RST);
    queue_word(KIND_POP, 8'h00);
    queue_word(KIND_POP, 8'hFF);
    wait_idle();

    write_chars(8'h00, 8'hFF);
    random_traffic(72, 45);
    wait_idle();
    // few pops: the ring fills and bytes get dropped
    write_chars(8'hFF, 8'h00);
    random_traffic(72, 10);
    wait_idle();
    // same char opens and closes
    write_chars(8'h7E, 8'h7E);
    random_traffic(72, 35);
    wait_idle();
    write_chars(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    random_traffic(72, 50);
    wait_idle();
    write_chars(START_CHAR_RST, END_CHAR_RST);
    random_traffic(72, 60);
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (due_words.size() != 0) begin
      n_errors += due_words.size();
      $display("%0d response words never arrived", due_words.size());
    end
    $display("Covered %0d byte words (%0d frames closed, %0d dropped) and %0d pops",
             n_bytes, n_closed, n_drops, n_pops);
    $display("  %0d payload bytes, %0d empty pops, %0d delimiter settings, %0d errors",
             n_payload, n_empty, n_settings, n_errors);
    if (n_errors == 0) begin
      $display("delimited_frame_ring_buffer_top: match");
    end else begin
      $display("delimited_frame_ring_buffer_top: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("delimited_frame_ring_buffer_top: mismatch");
    $finish;
  end

endmodule

### filelist.f
hdl/dfrb_pkg.sv
hdl/dfrb_ram.sv
hdl/dfrb_framer.sv
hdl/dfrb_seq.sv
hdl/delimited_frame_ring_buffer_top.sv
test/tb.sv
